// File: rtl/core/generation_ready_consumed_table_defines.svh
// Assertion macros for the handshake table checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef GENERATION_READY_CONSUMED_TABLE_DEFINES_SVH
`define GENERATION_READY_CONSUMED_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define GRCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("handshake table assertion failed");

// Next-cycle implication, disabled while reset is held
`define GRCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("handshake table assertion failed");

`endif

// File: rtl/core/grct_pkg.sv
package grct_pkg;

  // Table geometry
  localparam int MAX_RANKS = 64;
  localparam int MAX_SLOTS = 16;
  localparam int RANK_W    = $clog2(MAX_RANKS);
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int ADDR_W    = RANK_W + SLOT_W;
  localparam int ENTRIES   = MAX_RANKS * MAX_SLOTS;

  // Field widths
  localparam int GEN_W  = 63;
  localparam int TAG_W  = 64;
  localparam int MASK_W = 64;
  localparam int STAT_W = 3;
  localparam int WS_W   = 7;
  localparam int SC_W   = 5;
  localparam int CFG_W  = 7;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ACT_PUB_READY = 2'd0,
    ACT_CHK_READY = 2'd1,
    ACT_PUB_CONS  = 2'd2,
    ACT_CHK_CONS  = 2'd3
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_INVALID  = 3'd1,
    STAT_NOT_YET  = 3'd2,
    STAT_OVERRUN  = 3'd3,
    STAT_MISMATCH = 3'd4
  } stat_t;

  typedef enum logic {
    CFG_WORLD_SIZE = 1'b0,
    CFG_SLOT_COUNT = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_OUT
  } bst_t;

  // Classified command handed from front to back
  typedef struct packed {
    act_t              act;
    logic              bad;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic [TAG_W-1:0]  tag;
    logic              fail;
    logic [MASK_W-1:0] pending;
    logic [WS_W-1:0]   nr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  // Mask of the ranks below n
  function automatic logic [MASK_W-1:0] rank_mask(input logic [WS_W-1:0] n);
    logic [MASK_W-1:0] m;
    if (n >= WS_W'(MASK_W)) begin
      m = '1;
    end else begin
      m = (MASK_W'(1) << n) - MASK_W'(1);
    end
    return m;
  endfunction

endpackage

// File: rtl/core/generation_ready_consumed_table.sv
// Channel   Handshake             Payload
// config    cfg_wr_en             cfg_index, cfg_data
// input     in_valid / in_stall   action, rank, slot, generation, window_tag,
//                                 failed, pending_mask
// output    out_valid / out_stall status, ready_mask, failed_mask
//
// After reset the table is zeroed one entry a cycle, all 1024 entries, with in_stall high.
// Publishes go from the queue through the idle, execute and output states; valid checks also
// pass through a scan state that reads one rank per cycle through the table read port.
// A two-deep command queue keeps taking transactions, until it is full, while a result waits on out_stall.
module generation_ready_consumed_table import grct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [RANK_W-1:0] rank,
  input  logic [SLOT_W-1:0] slot,
  input  logic [GEN_W-1:0]  generation,
  input  logic [TAG_W-1:0]  window_tag,
  input  logic              failed,
  input  logic [MASK_W-1:0] pending_mask,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [MASK_W-1:0] ready_mask,
  output logic [MASK_W-1:0] failed_mask
);

  logic    push;
  logic    pop;
  logic    clearing;
  cmd_t    push_cmd;
  cmd_t    head;
  q_stat_t qs;

  // Accept and classify
  grct_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .rank         (rank),
    .slot         (slot),
    .generation   (generation),
    .window_tag   (window_tag),
    .failed       (failed),
    .pending_mask (pending_mask),
    .clearing     (clearing),
    .qs           (qs),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Command queue
  grct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qs       (qs)
  );

  // Table and execution
  grct_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qs          (qs),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .ready_mask  (ready_mask),
    .failed_mask (failed_mask)
  );

endmodule

// File: rtl/core/grct_front.sv
module grct_front import grct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [RANK_W-1:0] rank,
  input  logic [SLOT_W-1:0] slot,
  input  logic [GEN_W-1:0]  generation,
  input  logic [TAG_W-1:0]  window_tag,
  input  logic              failed,
  input  logic [MASK_W-1:0] pending_mask,
  input  logic              clearing,
  input  q_stat_t           qs,
  output logic              push,
  output cmd_t              cmd
);

  logic [WS_W-1:0] world_size;
  logic [SC_W-1:0] slot_count;
  logic [WS_W-1:0] nr;
  logic [SC_W-1:0] ns;
  logic            rank_bad;
  logic            slot_bad;
  logic            gen_zero;
  logic            bad;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      world_size <= WS_W'(2);
      slot_count <= SC_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WORLD_SIZE: world_size <= cfg_data[WS_W-1:0];
        CFG_SLOT_COUNT: slot_count <= cfg_data[SC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp registers to the supported range
  always_comb begin
    if (world_size < WS_W'(2)) begin
      nr = WS_W'(2);
    end else if (world_size > WS_W'(MAX_RANKS)) begin
      nr = WS_W'(MAX_RANKS);
    end else begin
      nr = world_size;
    end
    if (slot_count < SC_W'(1)) begin
      ns = SC_W'(1);
    end else if (slot_count > SC_W'(MAX_SLOTS)) begin
      ns = SC_W'(MAX_SLOTS);
    end else begin
      ns = slot_count;
    end
  end

  // Parameter checks per action
  assign rank_bad = {1'b0, rank} >= nr;
  assign slot_bad = {1'b0, slot} >= ns;
  assign gen_zero = (generation == '0);

  always_comb begin
    case (act_t'(action))
      ACT_PUB_READY: bad = rank_bad | slot_bad | gen_zero;
      ACT_CHK_READY: bad = slot_bad | gen_zero | (pending_mask == '0) |
                           ((pending_mask & ~rank_mask(nr)) != '0);
      ACT_PUB_CONS:  bad = rank_bad | slot_bad;
      ACT_CHK_CONS:  bad = slot_bad | gen_zero;
      default:       bad = 1'b1;
    endcase
  end

  // Take a transaction whenever the queue has room and the table is usable
  assign in_stall = qs.full | clearing;
  assign push     = in_valid & ~in_stall;

  always_comb begin
    cmd.act     = act_t'(action);
    cmd.bad     = bad;
    cmd.rank    = rank;
    cmd.slot    = slot;
    cmd.gen     = generation;
    cmd.tag     = window_tag;
    cmd.fail    = failed;
    cmd.pending = pending_mask;
    cmd.nr      = nr;
  end

endmodule

// File: rtl/core/grct_queue.sv
module grct_queue import grct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head,
  output q_stat_t qs
);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  assign head         = entries[rd_ptr];
  assign qs.full      = (count == CNT_W'(QDEPTH));
  assign qs.not_empty = (count != '0);

endmodule

// File: rtl/core/grct_back.sv
module grct_back import grct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  q_stat_t           qs,
  input  cmd_t              head,
  output logic              pop,
  output logic              clearing,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [STAT_W-1:0] status,
  output logic [MASK_W-1:0] ready_mask,
  output logic [MASK_W-1:0] failed_mask
);

  bst_t              state;
  bst_t              state_next;
  logic [ADDR_W-1:0] clr_cnt;
  cmd_t              cur;
  logic [WS_W-1:0]   rd_p;
  logic [RANK_W-1:0] ev_p;
  logic              ev_live;
  stat_t             res_status;
  logic [MASK_W-1:0] res_rmask;
  logic [MASK_W-1:0] res_fmask;

  // Table memories
  logic [GEN_W:0]    ready_mem [ENTRIES];
  logic [TAG_W-1:0]  win_mem   [ENTRIES];
  logic [GEN_W-1:0]  cons_mem  [ENTRIES];
  logic [GEN_W:0]    ready_rd;
  logic [TAG_W-1:0]  win_rd;
  logic [GEN_W-1:0]  cons_rd;

  logic              we_ready;
  logic              we_cons;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [GEN_W:0]    ready_wd;
  logic [TAG_W-1:0]  win_wd;
  logic [GEN_W-1:0]  cons_wd;
  logic              is_publish;

  logic              rd_live;
  logic              ev_eval;
  logic [GEN_W-1:0]  pg;
  logic              brk;
  stat_t             brk_stat;
  logic              last;
  logic              scan_done;
  stat_t             fin_stat;
  logic [MASK_W-1:0] rmask_upd;
  logic [MASK_W-1:0] fmask_upd;

  assign is_publish = (cur.act == ACT_PUB_READY) || (cur.act == ACT_PUB_CONS);

  // Scan: one rank read issued per cycle, evaluated in the cycle after it is issued
  assign rd_live = (state == S_SCAN) && (rd_p < cur.nr);
  assign ev_eval = ev_live && (state == S_SCAN);
  assign pg      = ready_rd[GEN_W:1];
  assign last    = ev_eval && ({1'b0, ev_p} == (cur.nr - WS_W'(1)));

  always_comb begin
    brk       = 1'b0;
    brk_stat  = STAT_OK;
    rmask_upd = res_rmask;
    fmask_upd = res_fmask;
    if (ev_eval) begin
      if (cur.act == ACT_CHK_READY) begin
        // ranks behind the requested generation are skipped
        if (cur.pending[ev_p] && (pg >= cur.gen)) begin
          if (pg != cur.gen) begin
            brk      = 1'b1;
            brk_stat = STAT_OVERRUN;
          end else if (win_rd != cur.tag) begin
            brk      = 1'b1;
            brk_stat = STAT_MISMATCH;
          end else begin
            rmask_upd[ev_p] = 1'b1;
            fmask_upd[ev_p] = ready_rd[0];
          end
        end
      end else if (cons_rd < cur.gen) begin
        brk      = 1'b1;
        brk_stat = STAT_NOT_YET;
      end
    end
  end

  assign scan_done = brk | last;

  always_comb begin
    if (brk) begin
      fin_stat = brk_stat;
    end else if ((cur.act == ACT_CHK_READY) && (rmask_upd == '0)) begin
      fin_stat = STAT_NOT_YET;
    end else begin
      fin_stat = STAT_OK;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_cnt == ADDR_W'(ENTRIES - 1)) state_next = S_IDLE;
      S_IDLE:  if (qs.not_empty) state_next = S_EXEC;
      S_EXEC:  state_next = (cur.bad || is_publish) ? S_OUT : S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_OUT;
      S_OUT:   if (!out_stall) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    pop       = (state == S_IDLE) && qs.not_empty;
    clearing  = (state == S_CLEAR);
    out_valid = (state == S_OUT);
    we_ready  = clearing ||
                ((state == S_EXEC) && !cur.bad && (cur.act == ACT_PUB_READY));
    we_cons   = clearing ||
                ((state == S_EXEC) && !cur.bad && (cur.act == ACT_PUB_CONS));
    waddr     = clearing ? clr_cnt : {cur.rank, cur.slot};
    ready_wd  = clearing ? '0 : {cur.gen, cur.fail};
    win_wd    = clearing ? '0 : cur.tag;
    cons_wd   = clearing ? '0 : cur.gen;
    raddr     = {rd_p[RANK_W-1:0], cur.slot};
  end

  assign status      = res_status;
  assign ready_mask  = res_rmask;
  assign failed_mask = res_fmask;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      ev_live <= 1'b0;
    end else begin
      state   <= state_next;
      ev_live <= rd_live & ~scan_done;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + ADDR_W'(1);
    end
  end

  // Command and result registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) cur <= head;
      end
      S_EXEC: begin
        rd_p       <= '0;
        res_rmask  <= '0;
        res_fmask  <= '0;
        res_status <= cur.bad ? STAT_INVALID : STAT_OK;
      end
      S_SCAN: begin
        if (rd_live) rd_p <= rd_p + WS_W'(1);
        ev_p <= rd_p[RANK_W-1:0];
        if (scan_done) begin
          res_status <= fin_stat;
          res_rmask  <= brk ? '0 : rmask_upd;
          res_fmask  <= brk ? '0 : fmask_upd;
        end else begin
          res_rmask  <= rmask_upd;
          res_fmask  <= fmask_upd;
        end
      end
      default: ;
    endcase
  end

  // Ready words
  always_ff @(posedge clk) begin
    if (we_ready) ready_mem[waddr] <= ready_wd;
    ready_rd <= ready_mem[raddr];
  end

  // Window tags
  always_ff @(posedge clk) begin
    if (we_ready) win_mem[waddr] <= win_wd;
    win_rd <= win_mem[raddr];
  end

  // Consumed generations
  always_ff @(posedge clk) begin
    if (we_cons) cons_mem[waddr] <= cons_wd;
    cons_rd <= cons_mem[raddr];
  end

endmodule

// File: rtl/core/grct_checker.sv
`include "generation_ready_consumed_table_defines.svh"

module grct_checker import grct_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [STAT_W-1:0] status,
  input logic [MASK_W-1:0] ready_mask,
  input logic [MASK_W-1:0] failed_mask
);

  // A stalled result holds
  `GRCT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(ready_mask) && $stable(failed_mask))

  // Only defined status codes leave the block
  `GRCT_ASSERT_IMP(a_status_code, out_valid, status <= STAT_MISMATCH)

  // Masks are only reported with a good status
  `GRCT_ASSERT_IMP(a_masks_ok_only, out_valid && (status != STAT_OK), (ready_mask == '0) && (failed_mask == '0))

  // A failed rank is always a ready rank
  `GRCT_ASSERT_IMP(a_failed_in_ready, out_valid, (failed_mask & ~ready_mask) == '0)

endmodule

bind generation_ready_consumed_table grct_checker u_grct_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .ready_mask  (ready_mask),
  .failed_mask (failed_mask)
);

// File: sim/tb_generation_ready_consumed_table.sv
`timescale 1ns / 1ps

module tb_generation_ready_consumed_table;
  import grct_pkg::*;

  localparam logic [GEN_W-1:0] GEN_TOP = '1;

  // One transaction on the input channel
  typedef struct packed {
    act_t              act;
    logic [RANK_W-1:0] rank;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic [TAG_W-1:0]  tag;
    logic              fail;
    logic [MASK_W-1:0] pend;
  } txn_t;

  // One expected result
  typedef struct packed {
    stat_t             st;
    logic [MASK_W-1:0] rdy;
    logic [MASK_W-1:0] flt;
  } outcome_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic              cfg_index = 1'b0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = '0;
  logic [RANK_W-1:0] rank = '0;
  logic [SLOT_W-1:0] slot = '0;
  logic [GEN_W-1:0]  generation = '0;
  logic [TAG_W-1:0]  window_tag = '0;
  logic              failed = 1'b0;
  logic [MASK_W-1:0] pending_mask = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [MASK_W-1:0] ready_mask;
  logic [MASK_W-1:0] failed_mask;

  generation_ready_consumed_table dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .rank(rank), .slot(slot), .generation(generation),
    .window_tag(window_tag), .failed(failed), .pending_mask(pending_mask),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .ready_mask(ready_mask), .failed_mask(failed_mask)
  );

  always #5 clk = ~clk;

  // Shadow copy of the table and its registers
  logic [GEN_W-1:0] rdy_gen  [ENTRIES];
  logic             rdy_fail [ENTRIES];
  logic [TAG_W-1:0] tag_mem  [ENTRIES];
  logic [GEN_W-1:0] cons_gen [ENTRIES];
  logic [WS_W-1:0]  world_reg = WS_W'(2);
  logic [SC_W-1:0]  slot_reg  = SC_W'(1);

  txn_t     txn_q[$];
  outcome_t outcome_q[$];
  txn_t     cur;
  int       mismatches = 0;
  int       phase_items = 0;
  logic     steady = 1'b0;
  int       hold_asks = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  int ws_plan[8] = '{0, 64, 127, 5, 1, 33, 64, 8};
  int sc_plan[8] = '{0, 16, 31, 3, 16, 7, 16, 4};

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      rdy_gen[i]  = '0;
      rdy_fail[i] = 1'b0;
      tag_mem[i]  = '0;
      cons_gen[i] = '0;
    end
  end

  // Effective geometry: registers clamped to the table size
  function automatic int ranks_used();
    int w;
    w = world_reg;
    if (w < 2) w = 2;
    if (w > MAX_RANKS) w = MAX_RANKS;
    return w;
  endfunction

  function automatic int slots_used();
    int s;
    s = slot_reg;
    if (s < 1) s = 1;
    if (s > MAX_SLOTS) s = MAX_SLOTS;
    return s;
  endfunction

  // Applies one transaction to the shadow table and returns its result
  function automatic outcome_t table_outcome(txn_t t);
    outcome_t          o;
    int                nr;
    int                ns;
    int                a;
    logic [MASK_W-1:0] live;
    o.st  = STAT_OK;
    o.rdy = '0;
    o.flt = '0;
    nr = ranks_used();
    ns = slots_used();
    live = (nr >= MASK_W) ? '1 : ((MASK_W'(1) << nr) - MASK_W'(1));
    case (t.act)
      ACT_PUB_READY: begin
        if (t.rank >= nr || t.slot >= ns || t.gen == '0) begin
          o.st = STAT_INVALID;
        end else begin
          a = t.rank * MAX_SLOTS + t.slot;
          rdy_gen[a]  = t.gen;
          rdy_fail[a] = t.fail;
          tag_mem[a]  = t.tag;
        end
      end
      ACT_CHK_READY: begin
        if (t.slot >= ns || t.gen == '0 || t.pend == '0 || (t.pend & ~live) != '0) begin
          o.st = STAT_INVALID;
        end else begin
          // ascending scan, first offending rank ends it
          for (int p = 0; p < nr; p++) begin
            if (t.pend[p]) begin
              a = p * MAX_SLOTS + t.slot;
              if (rdy_gen[a] >= t.gen) begin
                if (rdy_gen[a] != t.gen) begin
                  o.st = STAT_OVERRUN;
                  break;
                end
                if (tag_mem[a] != t.tag) begin
                  o.st = STAT_MISMATCH;
                  break;
                end
                o.rdy[p] = 1'b1;
                o.flt[p] = rdy_fail[a];
              end
            end
          end
          if (o.st != STAT_OK) begin
            o.rdy = '0;
            o.flt = '0;
          end else if (o.rdy == '0) begin
            o.st = STAT_NOT_YET;
          end
        end
      end
      ACT_PUB_CONS: begin
        if (t.rank >= nr || t.slot >= ns) begin
          o.st = STAT_INVALID;
        end else begin
          cons_gen[t.rank * MAX_SLOTS + t.slot] = t.gen;
        end
      end
      default: begin
        if (t.slot >= ns || t.gen == '0) begin
          o.st = STAT_INVALID;
        end else begin
          for (int p = 0; p < nr; p++) begin
            if (cons_gen[p * MAX_SLOTS + t.slot] < t.gen) begin
              o.st = STAT_NOT_YET;
              break;
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  // Sender: offers queued transactions, idles at random
  always @(posedge clk) begin : drive_p
    logic took;
    txn_t nxt;
    took = 1'b0;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        outcome_q = {outcome_q, table_outcome(cur)};
        took = 1'b1;
      end
      if (!in_valid || took) begin
        if (txn_q.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
          nxt = txn_q.pop_front();
          cur = nxt;
          action       <= nxt.act;
          rank         <= nxt.rank;
          slot         <= nxt.slot;
          generation   <= nxt.gen;
          window_tag   <= nxt.tag;
          failed       <= nxt.fail;
          pending_mask <= nxt.pend;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result against the oldest expectation
  always @(posedge clk) begin : watch_p
    outcome_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d", $time, status);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            mismatches++;
          end
          if (ready_mask !== want.rdy) begin
            $display("%0t: ready_mask expected %h actual %h", $time, want.rdy, ready_mask);
            mismatches++;
          end
          if (failed_mask !== want.flt) begin
            $display("%0t: failed_mask expected %h actual %h", $time, want.flt, failed_mask);
            mismatches++;
          end
        end
      end
      // long hold-off on request, otherwise random stalls outside the steady phase
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 36);
      end
    end
  end

  task automatic push_item(act_t a, int unsigned r, int unsigned s, logic [GEN_W-1:0] g,
                           logic [TAG_W-1:0] t, int unsigned f, logic [MASK_W-1:0] p);
    txn_t x;
    x.act  = a;
    x.rank = RANK_W'(r);
    x.slot = SLOT_W'(s);
    x.gen  = g;
    x.tag  = t;
    x.fail = f[0];
    x.pend = p;
    txn_q = {txn_q, x};
    phase_items++;
  endtask

  function automatic logic [GEN_W-1:0] rand_gen();
    logic [GEN_W-1:0] g;
    case ($urandom_range(3))
      0:       g = GEN_W'($urandom_range(20, 1));
      1:       g = GEN_TOP - GEN_W'($urandom_range(20, 0));
      default: g = GEN_W'({$urandom, $urandom});
    endcase
    if (g == '0) g = GEN_W'(1);
    return g;
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Publish ready on a few ranks, some spoilt, then check them
  task automatic ready_round();
    int unsigned       s;
    int unsigned       k;
    int unsigned       r;
    int unsigned       mode;
    int                nr;
    logic [GEN_W-1:0]  g;
    logic [TAG_W-1:0]  t;
    logic [MASK_W-1:0] pend;
    nr = ranks_used();
    s = $urandom_range(slots_used() - 1);
    g = rand_gen();
    if (g < 2) g = GEN_W'(2);
    if (g == GEN_TOP) g = GEN_TOP - 1;
    t = rand_tag();
    pend = '0;
    k = $urandom_range(nr < 6 ? nr : 6, 1);
    for (int j = 0; j < k; j++) begin
      r = $urandom_range(nr - 1);
      pend[r] = 1'b1;
      mode = $urandom_range(19);
      case (mode)
        0: push_item(ACT_PUB_READY, r, s, g + 1, t, $urandom_range(1), rand_tag());
        1: push_item(ACT_PUB_READY, r, s, g, t ^ (MASK_W'(1) << $urandom_range(63)),
                     $urandom_range(1), rand_tag());
        2: push_item(ACT_PUB_READY, r, s, g - 1, t, $urandom_range(1), rand_tag());
        3: ; // rank left unpublished
        default: push_item(ACT_PUB_READY, r, s, g, t, $urandom_range(1), rand_tag());
      endcase
    end
    if ($urandom_range(7) == 0) pend[$urandom_range(nr - 1)] = 1'b1;
    push_item(ACT_CHK_READY, $urandom_range(63), s, g, t, $urandom_range(1), pend);
  endtask

  // Publish consumed on most ranks, a few lagging or skipped, then check
  task automatic consumed_round();
    int unsigned      s;
    int unsigned      mode;
    int               nr;
    logic [GEN_W-1:0] g;
    nr = ranks_used();
    s = $urandom_range(slots_used() - 1);
    g = rand_gen();
    if (g < 2) g = GEN_W'(2);
    if (g > GEN_TOP - 4) g = GEN_TOP - 4;
    for (int r = 0; r < nr; r++) begin
      mode = $urandom_range(31);
      if (mode == 0) push_item(ACT_PUB_CONS, r, s, g - 1, rand_tag(), $urandom_range(1), '0);
      else if (mode != 1)
        push_item(ACT_PUB_CONS, r, s, g + $urandom_range(3), rand_tag(), $urandom_range(1),
                  {$urandom, $urandom});
    end
    push_item(ACT_CHK_CONS, $urandom_range(63), s, g + $urandom_range(1), rand_tag(),
              $urandom_range(1), {$urandom, $urandom});
  endtask

  // Fully random transaction, mostly malformed
  task automatic noise_item();
    logic [GEN_W-1:0]  g;
    logic [MASK_W-1:0] p;
    int                nr;
    nr = ranks_used();
    g = ($urandom_range(7) == 0) ? '0 : rand_gen();
    case ($urandom_range(2))
      0:       p = '0;
      1:       p = {$urandom, $urandom};
      default: p = {$urandom, $urandom} &
                   ((nr >= MASK_W) ? '1 : ((MASK_W'(1) << nr) - MASK_W'(1)));
    endcase
    push_item(act_t'($urandom_range(3)), $urandom_range(63), $urandom_range(15), g,
              rand_tag(), $urandom_range(1), p);
  endtask

  task automatic fill_phase(int n);
    int pick;
    int cons_pct;
    phase_items = 0;
    cons_pct = (ranks_used() <= 16) ? 20 : 6;
    while (phase_items < n) begin
      pick = $urandom_range(99);
      if (pick < 25) noise_item();
      else if (pick < 25 + cons_pct) consumed_round();
      else ready_round();
    end
  endtask

  task automatic wait_idle();
    while (txn_q.size() != 0 || in_valid || outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_WORLD_SIZE) world_reg = WS_W'(val);
    else slot_reg = SC_W'(val);
  endtask

  // Stimulus: directed checks at reset geometry, then random phases
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_item(ACT_CHK_READY, 0, 0, 1, '0, 0, 64'h3);          // nothing published yet
    push_item(ACT_CHK_CONS, 0, 0, 1, '0, 0, '0);
    push_item(ACT_PUB_READY, 0, 0, GEN_TOP, '1, 1, '0);
    push_item(ACT_PUB_READY, 1, 0, GEN_TOP, '1, 0, '1);
    push_item(ACT_CHK_READY, 63, 0, GEN_TOP, '1, 1, 64'h3);   // both ready, one failed
    push_item(ACT_CHK_READY, 0, 0, GEN_TOP, '0, 0, 64'h2);    // tag mismatch
    push_item(ACT_CHK_READY, 0, 0, GEN_TOP - 1, '1, 0, 64'h1); // overrun
    push_item(ACT_PUB_READY, 2, 0, 5, '0, 0, '0);              // rank outside world
    push_item(ACT_PUB_READY, 63, 15, 5, '0, 0, '0);
    push_item(ACT_PUB_READY, 0, 1, 5, '0, 0, '0);              // slot outside
    push_item(ACT_PUB_READY, 0, 0, '0, '0, 1, '0);             // zero generation
    push_item(ACT_CHK_READY, 0, 0, '0, '1, 0, 64'h3);
    push_item(ACT_CHK_READY, 0, 0, GEN_TOP, '1, 0, '0);        // empty pending mask
    push_item(ACT_CHK_READY, 0, 0, GEN_TOP, '1, 0, '1);
    push_item(ACT_CHK_READY, 0, 0, GEN_TOP, '1, 0, 64'h8000_0000_0000_0000);
    push_item(ACT_CHK_READY, 0, 15, GEN_TOP, '1, 0, 64'h1);
    push_item(ACT_PUB_CONS, 0, 0, '0, '0, 0, '0);              // zero consumed is fine
    push_item(ACT_PUB_CONS, 0, 0, GEN_TOP, '0, 0, '0);
    push_item(ACT_CHK_CONS, 0, 0, GEN_TOP, '0, 0, '0);         // rank 1 still behind
    push_item(ACT_PUB_CONS, 1, 0, GEN_TOP, '1, 1, '1);
    push_item(ACT_CHK_CONS, 0, 0, GEN_TOP, '0, 0, '0);
    push_item(ACT_CHK_CONS, 0, 0, '0, '0, 0, '0);
    push_item(ACT_CHK_CONS, 0, 1, 1, '0, 0, '0);
    push_item(ACT_PUB_CONS, 63, 15, 1, '0, 0, '0);
    push_item(ACT_PUB_READY, 0, 0, 1, '0, 0, '0);
    push_item(ACT_CHK_READY, 0, 0, 2, '0, 0, 64'h1);           // older generation only

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      repeat (100) @(posedge clk);
      write_reg(CFG_WORLD_SIZE, ws_plan[ph]);
      write_reg(CFG_SLOT_COUNT, sc_plan[ph]);
      steady = (ph == 6);
      fill_phase(230);
      // receiver backs off while the sender keeps offering
      if (ph == 1) hold_asks++;
    end

    wait_idle();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** generation_ready_consumed_table: PASSED **");
    end else begin
      $display("** generation_ready_consumed_table: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("** generation_ready_consumed_table: FAILED **");
    $finish;
  end

endmodule
